// ----- design/sfeps_pkg.sv -----
`default_nettype none
package sfeps_pkg;

  typedef enum logic [2:0] {
    CMD_RECOVER   = 3'd0,
    CMD_ERASE     = 3'd1,
    CMD_PROG_REQ  = 3'd2,
    CMD_PROG_BYTE = 3'd3,
    CMD_STATUS    = 3'd4,
    CMD_TICK      = 3'd5
  } cmd_code_t;

  typedef enum logic [1:0] {
    KIND_BYTE    = 2'd0,
    KIND_REPORT  = 2'd1,
    KIND_RELEASE = 2'd2
  } kind_code_t;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_BUSY_TIMEOUT = 2'd1,
    ST_BAD_ARG      = 2'd2,
    ST_BAD_SEQ      = 2'd3
  } status_code_t;

  localparam logic [7:0] OP_WREN = 8'h06;
  localparam logic [7:0] OP_RDSR = 8'h05;
  localparam logic [7:0] OP_PP   = 8'h02;
  localparam logic [7:0] OP_SE   = 8'h20;
  localparam logic [7:0] SR_BUSY = 8'h01;
  localparam logic [7:0] DUMMY   = 8'hFF;

  localparam logic [31:0] BUDGET_RESET = 32'd100000;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [23:0] address;
    logic [8:0]  length;
    logic [7:0]  data_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] bus_byte;
    logic       release_select;
    logic [1:0] status_code;
    logic       last;
  } out_item_t;

  // Work handed from the front to the back; each expands into a fixed run of results.
  typedef enum logic [2:0] {
    JOB_REPORT,
    JOB_RECOVER,
    JOB_POLL,
    JOB_DATA,
    JOB_DATA_LAST,
    JOB_ERASE,
    JOB_PROGRAM
  } job_kind_t;

  typedef struct packed {
    job_kind_t    job;
    logic [7:0]   data_byte;
    logic [23:0]  address;
    status_code_t status;
  } job_t;

endpackage
`default_nettype wire

// ----- design/sfeps_front.sv -----
`default_nettype none
module sfeps_front
  import sfeps_pkg::*;
#(
  parameter int FLASH_BYTES = 8388608,
  parameter int PAGE_BYTES  = 256
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire in_item_t    in_data,
  input  wire logic [31:0] busy_budget,
  input  wire logic        job_space,
  output logic             job_push,
  output job_t             job_data
);

  localparam int          PAGE_W    = $clog2(PAGE_BYTES);
  localparam logic [24:0] FLASH_LIM = 25'(FLASH_BYTES);
  localparam logic [8:0]  PAGE_LIM  = 9'(PAGE_BYTES);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_PRE,
    PH_DATA,
    PH_POST
  } phase_t;

  typedef enum logic [1:0] {
    OPN_NONE,
    OPN_RECOVER,
    OPN_ERASE,
    OPN_PROGRAM
  } operation_t;

  phase_t      phase_r, phase_nxt;
  operation_t  operation_r, operation_nxt;
  logic [23:0] target_r, target_nxt;
  logic [8:0]  bytes_left_r, bytes_left_nxt;
  logic [31:0] budget_left_r, budget_left_nxt;

  logic        has_job;
  logic        accept;
  logic        waiting;
  logic        erase_bad;
  logic        prog_bad;
  logic [24:0] prog_end;
  logic [8:0]  bytes_dec;

  assign in_ready  = job_space;
  assign accept    = in_valid && in_ready;
  assign job_push  = accept && has_job;
  assign waiting   = (phase_r == PH_PRE) || (phase_r == PH_POST);
  assign prog_end  = {1'b0, in_data.address} + {16'd0, in_data.length};
  assign erase_bad = {1'b0, in_data.address} >= FLASH_LIM;
  assign prog_bad  = (in_data.length == 9'd0) || (in_data.length > PAGE_LIM) ||
                     (in_data.address[PAGE_W-1:0] != '0) || (prog_end > FLASH_LIM);
  assign bytes_dec = bytes_left_r - 9'd1;

  always_comb begin
    phase_nxt          = phase_r;
    operation_nxt      = operation_r;
    target_nxt         = target_r;
    bytes_left_nxt     = bytes_left_r;
    budget_left_nxt    = budget_left_r;
    has_job            = 1'b0;
    job_data.job       = JOB_REPORT;
    job_data.data_byte = in_data.data_byte;
    job_data.address   = target_r;
    job_data.status    = ST_OK;
    unique case (in_data.cmd)
      CMD_RECOVER: begin
        has_job         = 1'b1;
        job_data.job    = JOB_RECOVER;
        operation_nxt   = OPN_RECOVER;
        bytes_left_nxt  = 9'd0;
        phase_nxt       = PH_PRE;
        budget_left_nxt = busy_budget;
      end
      CMD_ERASE, CMD_PROG_REQ: begin
        has_job = 1'b1;
        if (phase_r != PH_IDLE) begin
          job_data.status = ST_BAD_SEQ;
        end else if (in_data.cmd == CMD_ERASE && erase_bad) begin
          job_data.status = ST_BAD_ARG;
        end else if (in_data.cmd == CMD_PROG_REQ && prog_bad) begin
          job_data.status = ST_BAD_ARG;
        end else begin
          job_data.job    = JOB_POLL;
          target_nxt      = in_data.address;
          phase_nxt       = PH_PRE;
          budget_left_nxt = busy_budget;
          if (in_data.cmd == CMD_ERASE) begin
            operation_nxt = OPN_ERASE;
          end else begin
            operation_nxt  = OPN_PROGRAM;
            bytes_left_nxt = in_data.length;
          end
        end
      end
      CMD_PROG_BYTE: begin
        has_job = 1'b1;
        if (phase_r != PH_DATA || bytes_left_r == 9'd0) begin
          job_data.status = ST_BAD_SEQ;
        end else begin
          bytes_left_nxt = bytes_dec;
          if (bytes_dec == 9'd0) begin
            job_data.job    = JOB_DATA_LAST;
            phase_nxt       = PH_POST;
            budget_left_nxt = busy_budget;
          end else begin
            job_data.job = JOB_DATA;
          end
        end
      end
      CMD_STATUS: begin
        has_job = 1'b1;
        if (!waiting) begin
          job_data.status = ST_BAD_SEQ;
        end else if ((in_data.data_byte & SR_BUSY) != 8'd0) begin
          if (budget_left_r == 32'd0) begin
            job_data.status = ST_BUSY_TIMEOUT;
            phase_nxt       = PH_IDLE;
            operation_nxt   = OPN_NONE;
          end else begin
            job_data.job = JOB_POLL;
          end
        end else if (phase_r == PH_POST || operation_r == OPN_RECOVER ||
                     operation_r == OPN_NONE) begin
          job_data.status = ST_OK;
          phase_nxt       = PH_IDLE;
          operation_nxt   = OPN_NONE;
        end else if (operation_r == OPN_ERASE) begin
          job_data.job    = JOB_ERASE;
          phase_nxt       = PH_POST;
          budget_left_nxt = busy_budget;
        end else begin
          job_data.job = JOB_PROGRAM;
          phase_nxt    = PH_DATA;
        end
      end
      CMD_TICK: begin
        if (waiting && budget_left_r != 32'd0) begin
          budget_left_nxt = budget_left_r - 32'd1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_IDLE;
      operation_r   <= OPN_NONE;
      target_r      <= '0;
      bytes_left_r  <= '0;
      budget_left_r <= '0;
    end else if (accept) begin
      phase_r       <= phase_nxt;
      operation_r   <= operation_nxt;
      target_r      <= target_nxt;
      bytes_left_r  <= bytes_left_nxt;
      budget_left_r <= budget_left_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- design/sfeps_queue.sv -----
`default_nettype none
module sfeps_queue
  import sfeps_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire job_t push_data,
  output logic      space,
  input  wire logic pop,
  output logic      head_valid,
  output job_t      head_data
);

  job_t       mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       do_pop;

  assign space      = (count_r != 2'd2);
  assign head_valid = (count_r != 2'd0);
  assign head_data  = mem_r[rd_ptr_r];
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- design/sfeps_back.sv -----
`default_nettype none
module sfeps_back
  import sfeps_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic head_valid,
  input  wire job_t head_data,
  output logic      pop,
  output logic      out_valid,
  input  wire logic out_ready,
  output out_item_t out_data
);

  logic [2:0] step_r, step_nxt;
  logic       out_valid_r, out_valid_nxt;
  out_item_t  out_data_r, out_data_nxt;
  out_item_t  res;
  logic       load;

  function automatic out_item_t bus_byte_item(logic [7:0] b, logic rel, logic fin);
    out_item_t r;
    r.kind           = KIND_BYTE;
    r.bus_byte       = b;
    r.release_select = rel;
    r.status_code    = ST_OK;
    r.last           = fin;
    return r;
  endfunction

  // Result for the current step of the job at the head of the queue.
  always_comb begin
    res = bus_byte_item(DUMMY, 1'b1, 1'b1);
    unique case (head_data.job)
      JOB_REPORT: begin
        res.kind           = KIND_REPORT;
        res.bus_byte       = 8'd0;
        res.release_select = 1'b0;
        res.status_code    = head_data.status;
      end
      JOB_RECOVER: begin
        if (step_r == 3'd0) begin
          res.kind     = KIND_RELEASE;
          res.bus_byte = 8'd0;
          res.last     = 1'b0;
        end else if (step_r == 3'd1) begin
          res = bus_byte_item(OP_RDSR, 1'b0, 1'b0);
        end
      end
      JOB_POLL: begin
        if (step_r == 3'd0) begin
          res = bus_byte_item(OP_RDSR, 1'b0, 1'b0);
        end
      end
      JOB_DATA: begin
        res = bus_byte_item(head_data.data_byte, 1'b0, 1'b1);
      end
      JOB_DATA_LAST: begin
        if (step_r == 3'd0) begin
          res = bus_byte_item(head_data.data_byte, 1'b1, 1'b0);
        end else if (step_r == 3'd1) begin
          res = bus_byte_item(OP_RDSR, 1'b0, 1'b0);
        end
      end
      JOB_ERASE, JOB_PROGRAM: begin
        unique case (step_r)
          3'd0: res = bus_byte_item(OP_WREN, 1'b1, 1'b0);
          3'd1: res = bus_byte_item((head_data.job == JOB_ERASE) ? OP_SE : OP_PP,
                                    1'b0, 1'b0);
          3'd2: res = bus_byte_item(head_data.address[23:16], 1'b0, 1'b0);
          3'd3: res = bus_byte_item(head_data.address[15:8], 1'b0, 1'b0);
          3'd4: res = bus_byte_item(head_data.address[7:0],
                                    head_data.job == JOB_ERASE,
                                    head_data.job == JOB_PROGRAM);
          3'd5: res = bus_byte_item(OP_RDSR, 1'b0, 1'b0);
          default: res = bus_byte_item(DUMMY, 1'b1, 1'b1);
        endcase
      end
      default: begin
      end
    endcase
  end

  assign load      = head_valid && (!out_valid_r || out_ready);
  assign pop       = load && res.last;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (load) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res;
      step_nxt      = res.last ? 3'd0 : step_r + 3'd1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    if (!rst_n) begin
      step_r      <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- design/spi_flash_erase_program_sequencer_top.sv -----
// The first result of an input item passes through the job queue and the back-end output register.
// The back-end sequencer emits one result item per cycle while out_ready allows; an input item
// causes 1 to 7 results there, and items without results (ticks, spare codes) never reach it.
// A two-entry job queue lets the front accept while the back still emits.
// Reset (rst_n, synchronous, active low): idle phase, empty queue, budget register 100000.
`default_nettype none
module spi_flash_erase_program_sequencer_top
  import sfeps_pkg::*;
#(
  parameter int FLASH_BYTES = 8388608,
  parameter int PAGE_BYTES  = 256
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire in_item_t    in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output out_item_t        out_data,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [31:0] cfg_data
);

  logic [31:0] busy_budget_r, busy_budget_nxt;
  logic        job_space;
  logic        job_push;
  job_t        job_in;
  logic        head_valid;
  job_t        head_data;
  logic        job_pop;

  assign cfg_ready       = 1'b1;
  assign busy_budget_nxt = (cfg_valid && cfg_ready) ? cfg_data : busy_budget_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_budget_r <= BUDGET_RESET;
    end else begin
      busy_budget_r <= busy_budget_nxt;
    end
  end

  sfeps_front #(
    .FLASH_BYTES(FLASH_BYTES),
    .PAGE_BYTES (PAGE_BYTES)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .busy_budget(busy_budget_r),
    .job_space  (job_space),
    .job_push   (job_push),
    .job_data   (job_in)
  );

  sfeps_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (job_push),
    .push_data (job_in),
    .space     (job_space),
    .pop       (job_pop),
    .head_valid(head_valid),
    .head_data (head_data)
  );

  sfeps_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_valid(head_valid),
    .head_data (head_data),
    .pop       (job_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps

import sfeps_pkg::*;

typedef enum logic [1:0] {
  PH_IDLE,
  PH_PRE,
  PH_DATA,
  PH_POST
} seq_phase_t;

typedef enum logic [1:0] {
  OPN_NONE,
  OPN_RECOVER,
  OPN_ERASE,
  OPN_PROGRAM
} flash_op_t;

// Tracks the flash command sequence and keeps the bus items it predicts.
class flash_op_tracker #(int FLASH_BYTES = 8388608, int PAGE_BYTES = 256);
  logic [31:0] budget_reg;
  seq_phase_t  phase;
  flash_op_t   operation;
  logic [23:0] target_addr;
  logic [8:0]  bytes_left;
  logic [31:0] budget_left;
  out_item_t   pending[$];
  out_item_t   burst[$];
  int          mismatches;

  function new();
    budget_reg  = BUDGET_RESET;
    phase       = PH_IDLE;
    operation   = OPN_NONE;
    target_addr = '0;
    bytes_left  = '0;
    budget_left = '0;
    mismatches  = 0;
  endfunction

  function void set_budget(logic [31:0] value);
    budget_reg = value;
  endfunction

  function void emit(kind_code_t kind, logic [7:0] bus_byte, logic rel, status_code_t st);
    out_item_t item;
    item.kind           = kind;
    item.bus_byte       = bus_byte;
    item.release_select = rel;
    item.status_code    = st;
    item.last           = 1'b0;
    burst.push_back(item);
  endfunction

  function void start_poll(seq_phase_t next_phase);
    emit(KIND_BYTE, OP_RDSR, 1'b0, ST_OK);
    emit(KIND_BYTE, DUMMY, 1'b1, ST_OK);
    phase       = next_phase;
    budget_left = budget_reg;
  endfunction

  function void finish_op(status_code_t st);
    emit(KIND_REPORT, 8'h00, 1'b0, st);
    phase     = PH_IDLE;
    operation = OPN_NONE;
  endfunction

  // Returns 1 when the item causes results or is a tick while a poll is waiting.
  function bit note_request(in_item_t it);
    bit        waiting;
    bit        erase;
    out_item_t tail;
    waiting = (phase == PH_PRE || phase == PH_POST);
    burst.delete();
    case (it.cmd)
      CMD_RECOVER: begin
        emit(KIND_RELEASE, 8'h00, 1'b1, ST_OK);
        operation  = OPN_RECOVER;
        bytes_left = '0;
        start_poll(PH_PRE);
      end
      CMD_ERASE, CMD_PROG_REQ: begin
        if (phase != PH_IDLE) begin
          emit(KIND_REPORT, 8'h00, 1'b0, ST_BAD_SEQ);
        end else if (it.cmd == CMD_ERASE) begin
          if (int'(it.address) >= FLASH_BYTES) begin
            emit(KIND_REPORT, 8'h00, 1'b0, ST_BAD_ARG);
          end else begin
            operation   = OPN_ERASE;
            target_addr = it.address;
            start_poll(PH_PRE);
          end
        end else begin
          if (it.length == 0 || int'(it.length) > PAGE_BYTES ||
              int'(it.address) % PAGE_BYTES != 0 ||
              int'(it.address) + int'(it.length) > FLASH_BYTES) begin
            emit(KIND_REPORT, 8'h00, 1'b0, ST_BAD_ARG);
          end else begin
            operation   = OPN_PROGRAM;
            target_addr = it.address;
            bytes_left  = it.length;
            start_poll(PH_PRE);
          end
        end
      end
      CMD_PROG_BYTE: begin
        if (phase != PH_DATA || bytes_left == 0) begin
          emit(KIND_REPORT, 8'h00, 1'b0, ST_BAD_SEQ);
        end else begin
          bytes_left = bytes_left - 1'b1;
          if (bytes_left == 0) begin
            emit(KIND_BYTE, it.data_byte, 1'b1, ST_OK);
            start_poll(PH_POST);
          end else begin
            emit(KIND_BYTE, it.data_byte, 1'b0, ST_OK);
          end
        end
      end
      CMD_STATUS: begin
        if (!waiting) begin
          emit(KIND_REPORT, 8'h00, 1'b0, ST_BAD_SEQ);
        end else if ((it.data_byte & SR_BUSY) != 0) begin
          if (budget_left == 0) begin
            finish_op(ST_BUSY_TIMEOUT);
          end else begin
            emit(KIND_BYTE, OP_RDSR, 1'b0, ST_OK);
            emit(KIND_BYTE, DUMMY, 1'b1, ST_OK);
          end
        end else if (phase == PH_POST || operation == OPN_RECOVER ||
                     operation == OPN_NONE) begin
          finish_op(ST_OK);
        end else begin
          // Chip is ready: write enable, then the command with its address.
          erase = (operation == OPN_ERASE);
          emit(KIND_BYTE, OP_WREN, 1'b1, ST_OK);
          emit(KIND_BYTE, erase ? OP_SE : OP_PP, 1'b0, ST_OK);
          emit(KIND_BYTE, target_addr[23:16], 1'b0, ST_OK);
          emit(KIND_BYTE, target_addr[15:8], 1'b0, ST_OK);
          emit(KIND_BYTE, target_addr[7:0], erase, ST_OK);
          if (erase) begin
            start_poll(PH_POST);
          end else begin
            phase = PH_DATA;
          end
        end
      end
      CMD_TICK: begin
        if (waiting && budget_left != 0) begin
          budget_left = budget_left - 1;
        end
      end
      default: begin
      end
    endcase
    if (burst.size() > 0) begin
      tail      = burst.pop_back();
      tail.last = 1'b1;
      burst.push_back(tail);
      foreach (burst[i]) pending.push_back(burst[i]);
    end
    return burst.size() > 0 || (it.cmd == CMD_TICK && waiting);
  endfunction

  function void check_result(out_item_t got);
    out_item_t want;
    if (pending.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("unexpected item: kind=%0d byte=%02h rel=%0d status=%0d last=%0d",
                 got.kind, got.bus_byte, got.release_select, got.status_code, got.last);
      end
      return;
    end
    want = pending.pop_front();
    if (got.kind !== want.kind || got.bus_byte !== want.bus_byte ||
        got.release_select !== want.release_select ||
        got.status_code !== want.status_code || got.last !== want.last) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("mismatch: expected kind=%0d byte=%02h rel=%0d status=%0d last=%0d",
                 want.kind, want.bus_byte, want.release_select, want.status_code,
                 want.last);
        $display("          actual   kind=%0d byte=%02h rel=%0d status=%0d last=%0d",
                 got.kind, got.bus_byte, got.release_select, got.status_code, got.last);
      end
    end
  endfunction
endclass

module testbench;
  localparam int FLASH_BYTES     = 8388608;
  localparam int PAGE_BYTES      = 256;
  localparam int ITEMS_PER_PHASE = 48;
  localparam int SETTLE_CYCLES   = 8;
  localparam int HOLD_OFF_CYCLES = 200;
  localparam int STALL_LIMIT     = 4000;
  localparam logic [2:0] CMD_SPARE = 3'd6;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;
  logic      cfg_valid;
  logic      cfg_ready;
  logic [31:0] cfg_data;

  flash_op_tracker #(FLASH_BYTES, PAGE_BYTES) tracker;

  bit rx_stalls;
  bit tx_gaps;
  bit hold_off_req;
  int stall_cycles = 0;
  int effective_items = 0;

  spi_flash_erase_program_sequencer_top #(
    .FLASH_BYTES(FLASH_BYTES),
    .PAGE_BYTES (PAGE_BYTES)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 95) return $urandom_range(3, 8);
    return $urandom_range(20, 60);
  endfunction

  function automatic in_item_t mk_item(logic [2:0] cmd, logic [23:0] address,
                                       logic [8:0] length, logic [7:0] data_byte);
    in_item_t it;
    it.cmd       = cmd;
    it.address   = address;
    it.length    = length;
    it.data_byte = data_byte;
    return it;
  endfunction

  // Mostly well-formed command sequences that follow the predicted phase, with some noise.
  function automatic in_item_t next_random_item();
    in_item_t    it;
    int unsigned pick;
    int unsigned sel;
    it.cmd       = 3'($urandom_range(0, 7));
    it.address   = 24'($urandom);
    it.length    = 9'($urandom);
    it.data_byte = 8'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 8) return it;
    case (tracker.phase)
      PH_IDLE: begin
        if (pick < 50) begin
          it.cmd = CMD_ERASE;
          if ($urandom_range(0, 9) != 0) begin
            it.address = 24'($urandom_range(0, FLASH_BYTES - 1));
          end
        end else if (pick < 92) begin
          it.cmd     = CMD_PROG_REQ;
          it.address = 24'($urandom_range(0, FLASH_BYTES / PAGE_BYTES - 1) * PAGE_BYTES);
          sel = $urandom_range(0, 99);
          if (sel < 80) begin
            it.length = 9'($urandom_range(1, 6));
          end else if (sel < 84) begin
            it.length = 9'($urandom_range(7, 64));
          end else if (sel < 86) begin
            it.length = 9'($urandom_range(1, PAGE_BYTES));
          end else if (sel < 90) begin
            it.length = 9'($urandom_range(0, 1) ? 0 : $urandom_range(PAGE_BYTES + 1, 511));
          end else if (sel < 95) begin
            it.address = it.address | 24'($urandom_range(1, PAGE_BYTES - 1));
          end else begin
            it.address = 24'($urandom_range(FLASH_BYTES / PAGE_BYTES, 65535) * PAGE_BYTES);
          end
        end else begin
          it.cmd = CMD_RECOVER;
        end
      end
      PH_DATA: begin
        if (pick < 85) it.cmd = CMD_PROG_BYTE;
        else if (pick < 90) it.cmd = CMD_TICK;
        else if (pick < 95) it.cmd = CMD_STATUS;
        else it.cmd = CMD_RECOVER;
      end
      default: begin
        if (pick < 40) it.cmd = CMD_TICK;
        else if (pick < 90) it.cmd = CMD_STATUS;
        else if (pick < 95) it.cmd = CMD_RECOVER;
        else it.cmd = CMD_ERASE;
      end
    endcase
    return it;
  endfunction

  // Valid is left high when no gap follows, so the caller lowers it at the end of a run.
  task automatic send_item(input in_item_t it);
    in_data  <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (tracker.note_request(it)) effective_items++;
    if (tx_gaps && $urandom_range(0, 1) == 0) begin
      in_valid <= 1'b0;
      repeat (pick_gap()) @(posedge clk);
    end
  endtask

  task automatic write_budget(input logic [31:0] value);
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    tracker.set_budget(value);
  endtask

  task automatic wait_drained();
    while (tracker.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      stall_cycles = 0;
    end else begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
      if (out_valid && out_ready) tracker.check_result(out_data);
    end
  end

  initial begin
    out_ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_off_req) begin
        // Long hold-off so the job queue fills and the input side stalls.
        hold_off_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else if (rx_stalls && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat (pick_gap()) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin
    @(posedge clk);
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    in_item_t    seq[$];
    logic [31:0] phase_budget [0:6];
    int          start_count;
    tracker      = new();
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    cfg_valid    = 1'b0;
    cfg_data     = '0;
    rx_stalls    = 1'b1;
    tx_gaps      = 1'b1;
    hold_off_req = 1'b0;
    phase_budget = '{32'd3, 32'hFFFF_FFFF, 32'd1, 32'd0, 32'd2, 32'd6, BUDGET_RESET};
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Stray items, bad arguments, a busy erase, a two-byte program at the top page, recover.
    seq = '{
      mk_item(CMD_STATUS, 24'h000000, 9'd0, 8'h00),
      mk_item(CMD_PROG_BYTE, 24'hFFFFFF, 9'h1FF, 8'hFF),
      mk_item(CMD_TICK, 24'h000000, 9'd0, 8'h00),
      mk_item(CMD_SPARE, 24'h123456, 9'd5, 8'h5A),
      mk_item(CMD_ERASE, 24'(FLASH_BYTES), 9'd0, 8'h00),
      mk_item(CMD_ERASE, 24'hFFFFFF, 9'h1FF, 8'hFF),
      mk_item(CMD_PROG_REQ, 24'h000000, 9'd0, 8'h00),
      mk_item(CMD_PROG_REQ, 24'h000000, 9'd257, 8'h00),
      mk_item(CMD_PROG_REQ, 24'h000001, 9'd1, 8'h00),
      mk_item(CMD_PROG_REQ, 24'hFFFF00, 9'd1, 8'h00),
      mk_item(CMD_ERASE, 24'(FLASH_BYTES - 1), 9'd0, 8'h00),
      mk_item(CMD_ERASE, 24'h000000, 9'd0, 8'h00),
      mk_item(CMD_PROG_BYTE, 24'h000000, 9'd0, 8'hA5),
      mk_item(CMD_STATUS, 24'h000000, 9'd0, 8'hFF),
      mk_item(CMD_TICK, 24'h000000, 9'd0, 8'h00),
      mk_item(CMD_STATUS, 24'h000000, 9'd0, 8'hFE),
      mk_item(CMD_STATUS, 24'h000000, 9'd0, 8'h00),
      mk_item(CMD_PROG_REQ, 24'(FLASH_BYTES - PAGE_BYTES), 9'd2, 8'h00),
      mk_item(CMD_STATUS, 24'h000000, 9'd0, 8'h00),
      mk_item(CMD_STATUS, 24'h000000, 9'd0, 8'h00),
      mk_item(CMD_PROG_BYTE, 24'h000000, 9'd0, 8'h00),
      mk_item(CMD_PROG_BYTE, 24'h000000, 9'd0, 8'hFF),
      mk_item(CMD_STATUS, 24'h000000, 9'd0, 8'h00),
      mk_item(CMD_RECOVER, 24'h000000, 9'd0, 8'h00),
      mk_item(CMD_STATUS, 24'h000000, 9'd0, 8'h00)
    };
    foreach (seq[i]) send_item(seq[i]);
    in_valid <= 1'b0;
    wait_drained();

    // With no budget at all the first busy status times out.
    write_budget(32'd0);
    seq = '{
      mk_item(CMD_ERASE, 24'h001000, 9'd0, 8'h00),
      mk_item(CMD_STATUS, 24'h000000, 9'd0, 8'h01)
    };
    foreach (seq[i]) send_item(seq[i]);
    in_valid <= 1'b0;
    wait_drained();

    for (int p = 0; p < 7; p++) begin
      write_budget(phase_budget[p]);
      rx_stalls = (p != 4);
      tx_gaps   = (p != 1 && p != 4);
      if (p == 1) hold_off_req = 1'b1;
      start_count = effective_items;
      while (effective_items - start_count < ITEMS_PER_PHASE) begin
        send_item(next_random_item());
      end
      in_valid <= 1'b0;
      wait_drained();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.pending.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
